### src/dclfb_pkg.sv
// ----------------------------------------------------------------------------
// dclfb_pkg
// types and constants shared by the dual chip lcd framebuffer modules
// ----------------------------------------------------------------------------
package dclfb_pkg;

    localparam int SCREEN_BYTES = 1024;
    localparam int ADDR_W       = 10;
    localparam int COLS_TOTAL   = 128;
    localparam int ROWS_TOTAL   = 64;
    localparam int CHIP_BYTES   = 512;
    localparam int PAGE_ROWS    = 8;

    localparam int OFIFO_DEPTH = 4;
    localparam int OFIFO_PTR_W = 2;
    localparam int OFIFO_CNT_W = 3;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_SET   = 2'd1;
    localparam logic [1:0] OP_FILL  = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] pos_x;
        logic [7:0] pos_y;
        logic [7:0] rect_width;
        logic [7:0] rect_height;
        logic       pixel_on;
        logic       chip_select;
        logic [2:0] page_select;
    } t_in_item;

    typedef struct packed {
        logic       out_chip;
        logic [2:0] out_page;
        logic [5:0] out_column;
        logic [7:0] column_byte;
        logic       last_byte;
    } t_out_item;

    // one byte access issued by the sequencer
    typedef struct packed {
        logic              vld;
        logic              rdout;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        mask;
        logic              on;
        logic              last;
    } t_byte_op;

endpackage

### src/dclfb_mem.sv
// ----------------------------------------------------------------------------
// dclfb_mem
// 1024 x 8 pixel store, one write and one registered read port, with
// forwarding of a write that hits the address read in the same cycle
// ----------------------------------------------------------------------------
module dclfb_mem (
    input  logic                        i_clk,
    input  logic                        i_re,
    input  logic [dclfb_pkg::ADDR_W-1:0] i_raddr,
    input  logic                        i_we,
    input  logic [dclfb_pkg::ADDR_W-1:0] i_waddr,
    input  logic [7:0]                  i_wdata,
    output logic [7:0]                  o_rdata
);
    import dclfb_pkg::*;

    logic [7:0] r_mem [SCREEN_BYTES];
    logic [7:0] r_q;
    logic       r_fwd;
    logic [7:0] r_fwd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q        <= r_mem[i_raddr];
            r_fwd      <= i_we && (i_waddr == i_raddr);
            r_fwd_data <= i_wdata;
        end
    end

    assign o_rdata = r_fwd ? r_fwd_data : r_q;

endmodule

### src/dclfb_ofifo.sv
// ----------------------------------------------------------------------------
// dclfb_ofifo
// small output queue that decouples read out from the downstream stall
// ----------------------------------------------------------------------------
module dclfb_ofifo (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_push,
    input  dclfb_pkg::t_out_item             i_item,
    output logic [dclfb_pkg::OFIFO_CNT_W-1:0] o_count,
    output logic                             o_valid,
    output dclfb_pkg::t_out_item             o_item,
    input  logic                             i_stall
);
    import dclfb_pkg::*;

    t_out_item              r_buf [OFIFO_DEPTH];
    logic [OFIFO_PTR_W-1:0] r_wr_ptr;
    logic [OFIFO_PTR_W-1:0] r_rd_ptr;
    logic [OFIFO_CNT_W-1:0] r_count;
    logic                   w_pop;

    assign o_valid = (r_count != '0);
    assign o_item  = r_buf[r_rd_ptr];
    assign o_count = r_count;
    assign w_pop   = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr_ptr] <= i_item;
        end
    end

endmodule

### src/dclfb_seq.sv
// ----------------------------------------------------------------------------
// dclfb_seq
// command sequencer: turns each command into a stream of byte accesses
// ----------------------------------------------------------------------------
module dclfb_seq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  dclfb_pkg::t_in_item i_data,
    input  logic                i_room,
    output logic                o_stall,
    output dclfb_pkg::t_byte_op o_op
);
    import dclfb_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CLR  = 2'd1;
    localparam logic [1:0] S_FILL = 2'd2;
    localparam logic [1:0] S_READ = 2'd3;

    logic [1:0]        r_state, n_state;
    logic [ADDR_W-1:0] r_cnt, n_cnt;

    logic [6:0] r_x0;
    logic [5:0] r_y0;
    logic [6:0] r_hl;
    logic [6:0] r_wl_m1;
    logic       r_on;
    logic       r_sel_chip;
    logic [2:0] r_sel_page;

    logic       w_accept;
    logic [6:0] w_fill_x;
    logic [7:0] w_fill_mask;

    assign o_stall  = (r_state != S_IDLE);
    assign w_accept = (r_state == S_IDLE) && i_valid;
    assign w_fill_x = r_x0 + r_cnt[9:3];

    // row b of the current page lies in the band when its distance below the
    // top row, taken mod 64, is under the clipped height
    always_comb begin
        logic [5:0] diff;
        for (int b = 0; b < PAGE_ROWS; b++) begin
            diff           = {r_cnt[2:0], 3'(b)} - r_y0;
            w_fill_mask[b] = ({1'b0, diff} < r_hl);
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_op    = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_cnt = '0;
                    unique case (i_data.opcode)
                        OP_CLEAR: begin
                            n_state = S_CLR;
                        end
                        OP_SET: begin
                            o_op.vld  = 1'b1;
                            o_op.addr = {i_data.pos_x[6], i_data.pos_y[5:3],
                                         i_data.pos_x[5:0]};
                            o_op.mask = 8'd1 << i_data.pos_y[2:0];
                            o_op.on   = i_data.pixel_on;
                        end
                        OP_FILL: begin
                            if (i_data.rect_width != 8'd0 && i_data.rect_height != 8'd0) begin
                                n_state = S_FILL;
                            end
                        end
                        OP_READ: begin
                            n_state = S_READ;
                        end
                    endcase
                end
            end
            S_CLR: begin
                o_op.vld  = 1'b1;
                o_op.addr = r_cnt;
                o_op.mask = 8'hff;
                o_op.on   = 1'b0;
                n_cnt     = r_cnt + 1'b1;
                if (r_cnt == ADDR_W'(SCREEN_BYTES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_FILL: begin
                // r_cnt holds the column index in its upper bits, the page in its low three
                o_op.vld  = 1'b1;
                o_op.addr = {w_fill_x[6], r_cnt[2:0], w_fill_x[5:0]};
                o_op.mask = w_fill_mask;
                o_op.on   = r_on;
                n_cnt     = r_cnt + 1'b1;
                if (r_cnt[9:3] == r_wl_m1 && r_cnt[2:0] == 3'd7) begin
                    n_state = S_IDLE;
                end
            end
            S_READ: begin
                if (i_room) begin
                    o_op.vld   = 1'b1;
                    o_op.rdout = 1'b1;
                    o_op.addr  = {r_sel_chip, r_sel_page, r_cnt[5:0]};
                    o_op.last  = (r_cnt[5:0] == 6'd63);
                    n_cnt      = r_cnt + 1'b1;
                    if (r_cnt[5:0] == 6'd63) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // reset starts with a sweep that zeroes the store
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_x0       <= i_data.pos_x[6:0];
            r_y0       <= i_data.pos_y[5:0];
            r_hl       <= (i_data.rect_height > 8'(ROWS_TOTAL)) ? 7'(ROWS_TOTAL)
                                                                : i_data.rect_height[6:0];
            r_wl_m1    <= (i_data.rect_width >= 8'(COLS_TOTAL)) ? 7'(COLS_TOTAL - 1)
                                                                : i_data.rect_width[6:0] - 1'b1;
            r_on       <= i_data.pixel_on;
            r_sel_chip <= i_data.chip_select;
            r_sel_page <= i_data.page_select;
        end
    end

endmodule

### src/dual_chip_lcd_framebuffer_unit.sv
// ----------------------------------------------------------------------------
// dual_chip_lcd_framebuffer_unit
// 128x64 page framebuffer over two chips: pixel, rectangle, clear, read out
// ----------------------------------------------------------------------------
// set pixel: accepted back to back, as a read-modify-write of one byte
// clear: a sweep of all 1024 bytes, fill: all eight pages of min(width,128) columns, none for a zero width or height
// read out: 64 bytes at one per cycle while the output queue has room
// the pixel store has a single write port and a registered read
// after reset a clearing pass zeroes the store with input stall high
module dual_chip_lcd_framebuffer_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  dclfb_pkg::t_in_item  i_data,
    output logic                 o_valid,
    input  logic                 i_stall,
    output dclfb_pkg::t_out_item o_data
);
    import dclfb_pkg::*;

    t_byte_op               w_op;
    t_byte_op               r_s2_op;
    logic                   r_s2_vld;
    logic [7:0]             w_rdata;
    logic [7:0]             w_wdata;
    logic                   w_we;
    logic                   w_push;
    t_out_item              w_push_item;
    logic [OFIFO_CNT_W-1:0] w_count;
    logic                   w_room;

    // a read out issues only while a queue slot is free for it
    assign w_push = r_s2_vld && r_s2_op.rdout;
    assign w_room = (w_count + OFIFO_CNT_W'(w_push)) < OFIFO_CNT_W'(OFIFO_DEPTH);

    dclfb_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_data  (i_data),
        .i_room  (w_room),
        .o_stall (o_stall),
        .o_op    (w_op)
    );

    dclfb_mem u_mem (
        .i_clk   (i_clk),
        .i_re    (w_op.vld),
        .i_raddr (w_op.addr),
        .i_we    (w_we),
        .i_waddr (r_s2_op.addr),
        .i_wdata (w_wdata),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else begin
            r_s2_vld <= w_op.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_op <= w_op;
    end

    // write back stage
    assign w_we    = r_s2_vld && !r_s2_op.rdout;
    assign w_wdata = r_s2_op.on ? (w_rdata | r_s2_op.mask) : (w_rdata & ~r_s2_op.mask);

    always_comb begin
        w_push_item.out_chip    = r_s2_op.addr[9];
        w_push_item.out_page    = r_s2_op.addr[8:6];
        w_push_item.out_column  = r_s2_op.addr[5:0];
        w_push_item.column_byte = w_rdata;
        w_push_item.last_byte   = r_s2_op.last;
    end

    dclfb_ofifo u_ofifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .o_count (w_count),
        .o_valid (o_valid),
        .o_item  (o_data),
        .i_stall (i_stall)
    );

endmodule

### test/dual_chip_lcd_framebuffer_unit_test.sv
// ----------------------------------------------------------------------------
// dual_chip_lcd_framebuffer_unit_test
// drives clear, pixel, rectangle and page read-out commands into the
// framebuffer and keeps a shadow copy of the 1024-byte store; every
// read-out byte is compared against the shadow, with random gaps on the
// command side and random stalls on the read-out side
// ----------------------------------------------------------------------------
module dual_chip_lcd_framebuffer_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import dclfb_pkg::*;

    localparam int PAGE_COLS     = 64;
    localparam int RESET_CYCLES  = 7;
    localparam int SETTLE_CYCLES = 1100;
    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int MAX_REPORTS   = 20;

    logic      i_clk;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_stall;
    t_in_item  i_data  = '0;
    logic      o_valid;
    logic      i_stall = 1'b0;
    t_out_item o_data;

    dual_chip_lcd_framebuffer_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    logic [7:0] shadow_store [SCREEN_BYTES];
    t_out_item  pending_bytes [$];
    t_out_item  want_byte;

    bit gaps_on   = 1'b0;
    bit stalls_on = 1'b0;
    int stall_left    = 0;
    int cycle_count   = 0;
    int error_count   = 0;
    int bytes_checked = 0;
    int n_clear = 0;
    int n_set   = 0;
    int n_fill  = 0;
    int n_read  = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic int pick_pause(bit enabled);
        int r;
        if (!enabled) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 24);
    endfunction

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS) begin
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
        end
    endtask

    function automatic void plot_pixel(int unsigned x, int unsigned y, logic on);
        int unsigned xw, yw, idx;
        xw  = x % COLS_TOTAL;
        yw  = y % ROWS_TOTAL;
        idx = (xw / PAGE_COLS) * CHIP_BYTES + (yw / PAGE_ROWS) * PAGE_COLS + xw % PAGE_COLS;
        shadow_store[idx][yw % PAGE_ROWS] = on;
    endfunction

    // updates the shadow store and queues the bytes a read-out will return
    function automatic void apply_command(t_in_item cmd);
        int unsigned wl, hl, base;
        t_out_item b;
        case (cmd.opcode)
            OP_CLEAR: begin
                foreach (shadow_store[k]) shadow_store[k] = '0;
                n_clear++;
            end
            OP_SET: begin
                plot_pixel(32'(cmd.pos_x), 32'(cmd.pos_y), cmd.pixel_on);
                n_set++;
            end
            OP_FILL: begin
                // anything past the screen size only lands on pixels already written
                wl = (cmd.rect_width > COLS_TOTAL) ? COLS_TOTAL : cmd.rect_width;
                hl = (cmd.rect_height > ROWS_TOTAL) ? ROWS_TOTAL : cmd.rect_height;
                for (int i = 0; i < wl; i++) begin
                    for (int j = 0; j < hl; j++) begin
                        plot_pixel(cmd.pos_x + i, cmd.pos_y + j, cmd.pixel_on);
                    end
                end
                n_fill++;
            end
            OP_READ: begin
                base = cmd.chip_select * CHIP_BYTES + cmd.page_select * PAGE_COLS;
                for (int col = 0; col < PAGE_COLS; col++) begin
                    b.out_chip    = cmd.chip_select;
                    b.out_page    = cmd.page_select;
                    b.out_column  = col[5:0];
                    b.column_byte = shadow_store[base + col];
                    b.last_byte   = (col == PAGE_COLS - 1);
                    pending_bytes.push_back(b);
                end
                n_read++;
            end
        endcase
    endfunction

    function automatic t_in_item noise_command();
        t_in_item c;
        c.opcode      = 2'($urandom);
        c.pos_x       = 8'($urandom);
        c.pos_y       = 8'($urandom);
        c.rect_width  = 8'($urandom);
        c.rect_height = 8'($urandom);
        c.pixel_on    = 1'($urandom);
        c.chip_select = 1'($urandom);
        c.page_select = 3'($urandom);
        return c;
    endfunction

    function automatic t_in_item random_command();
        t_in_item c;
        int r;
        c = noise_command();
        r = $urandom_range(0, 99);
        if (r < 4) begin
            c.opcode = OP_CLEAR;
        end else if (r < 45) begin
            c.opcode = OP_SET;
        end else if (r < 70) begin
            c.opcode = OP_FILL;
            // fill time grows with width, so most rectangles stay narrow
            if ($urandom_range(0, 9) < 8) c.rect_width = 8'($urandom_range(0, 20));
        end else begin
            c.opcode = OP_READ;
        end
        return c;
    endfunction

    task automatic send_command(input t_in_item cmd);
        int gap;
        gap = pick_pause(gaps_on);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= cmd;
        @(posedge i_clk);
        while (o_stall !== 1'b0) @(posedge i_clk);
        apply_command(cmd);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_bytes.size() != 0) @(posedge i_clk);
    endtask

    task automatic clear_screen();
        t_in_item c;
        c = noise_command();
        c.opcode = OP_CLEAR;
        send_command(c);
    endtask

    task automatic draw_pixel(input int x, input int y, input bit on);
        t_in_item c;
        c = noise_command();
        c.opcode   = OP_SET;
        c.pos_x    = 8'(x);
        c.pos_y    = 8'(y);
        c.pixel_on = on;
        send_command(c);
    endtask

    task automatic draw_rect(input int x, input int y, input int w, input int h, input bit on);
        t_in_item c;
        c = noise_command();
        c.opcode      = OP_FILL;
        c.pos_x       = 8'(x);
        c.pos_y       = 8'(y);
        c.rect_width  = 8'(w);
        c.rect_height = 8'(h);
        c.pixel_on    = on;
        send_command(c);
    endtask

    task automatic read_page(input bit chip, input int page);
        t_in_item c;
        c = noise_command();
        c.opcode      = OP_READ;
        c.chip_select = chip;
        c.page_select = 3'(page);
        send_command(c);
    endtask

    // corners, coordinate wrap, erase, empty and oversized rectangles
    task automatic test_directed_draws();
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        clear_screen();
        draw_pixel(0, 0, 1'b1);
        draw_pixel(127, 63, 1'b1);
        draw_pixel(255, 255, 1'b1);
        draw_pixel(64, 8, 1'b1);
        draw_pixel(200, 100, 1'b1);
        read_page(1'b0, 0);
        read_page(1'b1, 7);
        draw_pixel(127, 63, 1'b0);
        read_page(1'b1, 7);
        draw_rect(120, 60, 16, 10, 1'b1);
        draw_rect(0, 0, 0, 50, 1'b1);
        draw_rect(10, 10, 50, 0, 1'b1);
        read_page(1'b0, 7);
        read_page(1'b1, 7);
        draw_rect(0, 0, 255, 255, 1'b1);
        read_page(1'b0, 3);
        draw_rect(5, 3, 255, 1, 1'b0);
        read_page(1'b1, 0);
        clear_screen();
        read_page(1'b0, 0);
        wait_drained();
    endtask

    // phases of random commands, some with no idling; the sender holds off
    // at the end of each phase until every read-out byte has come back
    task automatic test_random_traffic(input int n_items);
        int per_phase;
        per_phase = n_items / 6;
        for (int p = 0; p < 6; p++) begin
            gaps_on   = (p == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
            stalls_on = (p == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
            repeat (per_phase) send_command(random_command());
            wait_drained();
        end
    endtask

    // every chip and page in turn, checking the whole store
    task automatic test_full_flash();
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        for (int chip = 0; chip < 2; chip++) begin
            for (int page = 0; page < 8; page++) begin
                read_page(chip[0], page);
            end
        end
        wait_drained();
    endtask

    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            i_stall <= 1'b1;
            stall_left--;
        end else begin
            i_stall <= 1'b0;
            stall_left = pick_pause(stalls_on);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && !i_stall) begin
            if (pending_bytes.size() == 0) begin
                report_mismatch($sformatf("byte with no read-out pending: chip %0d page %0d col %0d",
                                          o_data.out_chip, o_data.out_page,
                                          o_data.out_column));
            end else begin
                want_byte = pending_bytes.pop_front();
                bytes_checked++;
                if (o_data.out_chip !== want_byte.out_chip)
                    report_mismatch($sformatf("out_chip got %0d want %0d",
                                              o_data.out_chip, want_byte.out_chip));
                if (o_data.out_page !== want_byte.out_page)
                    report_mismatch($sformatf("out_page got %0d want %0d",
                                              o_data.out_page, want_byte.out_page));
                if (o_data.out_column !== want_byte.out_column)
                    report_mismatch($sformatf("out_column got %0d want %0d",
                                              o_data.out_column, want_byte.out_column));
                if (o_data.column_byte !== want_byte.column_byte)
                    report_mismatch($sformatf("column_byte got %h want %h (chip %0d page %0d col %0d)",
                                              o_data.column_byte, want_byte.column_byte,
                                              want_byte.out_chip, want_byte.out_page,
                                              want_byte.out_column));
                if (o_data.last_byte !== want_byte.last_byte)
                    report_mismatch($sformatf("last_byte got %0d want %0d at col %0d",
                                              o_data.last_byte, want_byte.last_byte,
                                              want_byte.out_column));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("dual_chip_lcd_framebuffer_unit test failed");
            $finish;
        end
    end

    initial begin
        foreach (shadow_store[k]) shadow_store[k] = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_draws();
        test_random_traffic(312);
        test_full_flash();

        // the last read-outs have drained; idle before printing the summary
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("covered %0d clears, %0d pixel writes, %0d rectangle fills, %0d page read-outs",
                 n_clear, n_set, n_fill, n_read);
        $display("%0d column bytes compared, %0d mismatches", bytes_checked, error_count);
        if (error_count == 0 && pending_bytes.size() == 0) begin
            $display("dual_chip_lcd_framebuffer_unit test passed");
        end else begin
            $display("dual_chip_lcd_framebuffer_unit test failed");
        end
        $finish;
    end

endmodule
